// ===== src/assert_macros.svh =====
// Assertion macros shared by the policy RTL.
// Depends on a clock named clk and a reset named rst in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// check outside reset
`define LPC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check that also covers the reset cycles
`define LPC_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ===== src/lfu_pkg.sv =====
// Package for the LFU page cache policy: sizes, entry types, saturating count.
// No dependencies.
package lfu_pkg;
  localparam int CACHE_SLOTS = 256;
  localparam int NUM_PAGES   = 65536;
  localparam int COUNT_BITS  = 16;
  localparam int STAMP_BITS  = 32;
  localparam int SLOT_BITS   = $clog2(CACHE_SLOTS);
  localparam int PAGE_BITS   = $clog2(NUM_PAGES);

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [STAMP_BITS-1:0] stamp_t;
  typedef logic [SLOT_BITS-1:0]  slot_idx_t;
  typedef logic [PAGE_BITS-1:0]  page_t;

  typedef struct packed {
    count_t    count;
    logic      resident;
    slot_idx_t slot;
  } page_entry_t;

  typedef struct packed {
    page_t  page;
    count_t count;
    stamp_t stamp;
    logic   dirty;
    logic [1:0] cls;
  } slot_entry_t;

  typedef struct packed {
    slot_idx_t  idx;
    page_t      page;
    logic       dirty;
    logic [1:0] cls;
  } victim_t;

  function automatic count_t count_up(count_t c);
    return (c == {COUNT_BITS{1'b1}}) ? c : count_t'(c + 1'b1);
  endfunction
endpackage

// ===== src/lfu_ifs.sv =====
// Valid/ready channel interfaces for page accesses and policy results.
// No dependencies.
interface lfu_req_if;
  logic        valid;
  logic        ready;
  logic [15:0] page_number;
  logic [1:0]  size_class;
  logic        is_write;
  modport source (output valid, page_number, size_class, is_write, input ready);
  modport sink (input valid, page_number, size_class, is_write, output ready);
endinterface

interface lfu_rsp_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [7:0]  slot;
  logic        fetch_needed;
  logic        evicted_valid;
  logic [15:0] evicted_page;
  logic        evicted_writeback;
  logic [1:0]  evicted_size_class;
  modport source (output valid, hit, slot, fetch_needed, evicted_valid, evicted_page,
                  evicted_writeback, evicted_size_class, input ready);
  modport sink (input valid, hit, slot, fetch_needed, evicted_valid, evicted_page,
                evicted_writeback, evicted_size_class, output ready);
endinterface

// ===== src/lfu_page_table.sv =====
// Page table memory: count, resident flag and slot per page, with the
// clearing pass after reset. Depends on lfu_pkg.
module lfu_page_table import lfu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        rd_en,
  input  page_t       rd_addr,
  output page_entry_t rd_data,
  input  logic        wr_en,
  input  page_t       wr_addr,
  input  page_entry_t wr_data,
  output logic        busy
);
  page_entry_t mem [NUM_PAGES];
  page_t       clr_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b1;
      clr_idx <= '0;
    end else if (busy) begin
      clr_idx <= page_t'(clr_idx + 1'b1);
      if (clr_idx == page_t'(NUM_PAGES - 1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (busy && !rst) begin
      mem[clr_idx] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) rd_data <= mem[rd_addr];
  end
endmodule

// ===== src/lfu_slot_store.sv =====
// Slot memory: page, count, stamp, dirty and size class per cache slot.
// Depends on lfu_pkg.
module lfu_slot_store import lfu_pkg::*; (
  input  logic        clk,
  input  logic        rd_en,
  input  slot_idx_t   rd_addr,
  output slot_entry_t rd_data,
  input  logic        wr_en,
  input  slot_idx_t   wr_addr,
  input  slot_entry_t wr_data
);
  slot_entry_t mem [CACHE_SLOTS];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end
endmodule

// ===== src/lfu_victim_pick.sv =====
// Running victim selection over the slot scan: lowest count, then oldest stamp,
// then lowest index. Depends on lfu_pkg.
module lfu_victim_pick import lfu_pkg::*; (
  input  logic        clk,
  input  logic        cmp_valid,
  input  slot_idx_t   cmp_idx,
  input  slot_entry_t entry,
  input  stamp_t      access_clock,
  output victim_t     best
);
  count_t best_count;
  stamp_t best_age;
  stamp_t age;
  logic   take;

  always_comb begin
    age  = stamp_t'(access_clock - entry.stamp);
    take = (cmp_idx == '0) || (entry.count < best_count) ||
           (entry.count == best_count && age > best_age);
  end

  always_ff @(posedge clk) begin
    if (cmp_valid && take) begin
      best_count <= entry.count;
      best_age   <= age;
      best.idx   <= cmp_idx;
      best.page  <= entry.page;
      best.dirty <= entry.dirty;
      best.cls   <= entry.cls;
    end
  end
endmodule

// ===== src/lfu_page_cache_policy.sv =====
// Top level of the LFU page cache policy: control sequencer around the page
// table, the slot store and the victim scan. Depends on lfu_pkg, lfu_ifs.
//
// channel | dir | carries
// req     | in  | page_number, size_class, is_write
// rsp     | out | hit, slot, fetch_needed, evicted_* fields
//
// Hit: LOOK, then HIT_WR. Miss into a free slot: LOOK, then FILL. Miss with a
// full cache: LOOK, the one-read-a-cycle scan of the slot store in SCAN, then
// SCAN_END, EV_RD, EV_WR and FILL. One transaction in flight at a time.
// After reset the page table is cleared while req.ready is low.
// A stalled rsp holds the sequencer in its last step until the slot drains.
module lfu_page_cache_policy import lfu_pkg::*; (
  input logic      clk,
  input logic      rst,
  lfu_req_if.sink   req,
  lfu_rsp_if.source rsp
);
`include "assert_macros.svh"

  localparam logic [3:0] ST_CLR      = 4'd0;
  localparam logic [3:0] ST_IDLE     = 4'd1;
  localparam logic [3:0] ST_LOOK     = 4'd2;
  localparam logic [3:0] ST_HIT_WR   = 4'd3;
  localparam logic [3:0] ST_SCAN     = 4'd4;
  localparam logic [3:0] ST_SCAN_END = 4'd5;
  localparam logic [3:0] ST_EV_RD    = 4'd6;
  localparam logic [3:0] ST_EV_WR    = 4'd7;
  localparam logic [3:0] ST_FILL     = 4'd8;

  logic [3:0] state, state_next;
  logic         clr_busy;
  page_t        cur_page;
  logic [1:0]   cur_cls;
  logic         cur_wr;
  count_t       cnt_new;
  slot_idx_t    work_slot;
  logic         evict;
  logic [SLOT_BITS:0] slots_in_use;
  stamp_t       access_clock;
  slot_idx_t    scan_idx;
  logic         cmp_valid;
  slot_idx_t    cmp_idx;
  victim_t      best;
  logic         out_v;
  logic         finish;

  logic        pt_rd_en, pt_wr_en;
  page_t       pt_rd_addr, pt_wr_addr;
  page_entry_t pt_rd_data, pt_wr_data;
  logic        ss_rd_en, ss_wr_en;
  slot_idx_t   ss_rd_addr, ss_wr_addr;
  slot_entry_t ss_rd_data, ss_wr_data;

  lfu_page_table u_pt (
    .clk, .rst, .rd_en(pt_rd_en), .rd_addr(pt_rd_addr), .rd_data(pt_rd_data),
    .wr_en(pt_wr_en), .wr_addr(pt_wr_addr), .wr_data(pt_wr_data), .busy(clr_busy)
  );

  lfu_slot_store u_ss (
    .clk, .rd_en(ss_rd_en), .rd_addr(ss_rd_addr), .rd_data(ss_rd_data),
    .wr_en(ss_wr_en), .wr_addr(ss_wr_addr), .wr_data(ss_wr_data)
  );

  lfu_victim_pick u_vp (
    .clk, .cmp_valid, .cmp_idx, .entry(ss_rd_data), .access_clock, .best
  );

  assign req.ready = (state == ST_IDLE);
  assign rsp.valid = out_v;

  always_comb begin
    state_next = state;
    pt_rd_en   = 1'b0;
    pt_rd_addr = page_t'(req.page_number);
    pt_wr_en   = 1'b0;
    pt_wr_addr = cur_page;
    pt_wr_data = '{count: cnt_new, resident: 1'b1, slot: work_slot};
    ss_rd_en   = 1'b0;
    ss_rd_addr = scan_idx;
    ss_wr_en   = 1'b0;
    ss_wr_addr = work_slot;
    ss_wr_data = '{page: cur_page, count: cnt_new, stamp: access_clock,
                   dirty: cur_wr, cls: cur_cls};
    finish     = 1'b0;
    case (state)
      ST_CLR: begin
        if (!clr_busy) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (req.valid) begin
          pt_rd_en   = 1'b1;
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (pt_rd_data.resident) begin
          pt_wr_en   = 1'b1;
          pt_wr_data = '{count: count_up(pt_rd_data.count), resident: 1'b1,
                         slot: pt_rd_data.slot};
          ss_rd_en   = 1'b1;
          ss_rd_addr = pt_rd_data.slot;
          state_next = ST_HIT_WR;
        end else if (slots_in_use == (SLOT_BITS+1)'(CACHE_SLOTS)) begin
          state_next = ST_SCAN;
        end else begin
          state_next = ST_FILL;
        end
      end
      ST_HIT_WR: begin
        ss_wr_data = '{page: ss_rd_data.page, count: count_up(ss_rd_data.count),
                       stamp: access_clock, dirty: ss_rd_data.dirty | cur_wr,
                       cls: ss_rd_data.cls};
        if (!out_v) begin
          ss_wr_en   = 1'b1;
          finish     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_SCAN: begin
        ss_rd_en = 1'b1;
        if (scan_idx == slot_idx_t'(CACHE_SLOTS - 1)) state_next = ST_SCAN_END;
      end
      ST_SCAN_END: begin
        state_next = ST_EV_RD;
      end
      ST_EV_RD: begin
        pt_rd_en   = 1'b1;
        pt_rd_addr = best.page;
        state_next = ST_EV_WR;
      end
      ST_EV_WR: begin
        // drop residency of the victim page, keep its count
        pt_wr_en   = 1'b1;
        pt_wr_addr = best.page;
        pt_wr_data = '{count: pt_rd_data.count, resident: 1'b0, slot: pt_rd_data.slot};
        state_next = ST_FILL;
      end
      ST_FILL: begin
        if (!out_v) begin
          pt_wr_en   = 1'b1;
          ss_wr_en   = 1'b1;
          finish     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLR;
      slots_in_use <= '0;
      access_clock <= '0;
      out_v        <= 1'b0;
      cmp_valid    <= 1'b0;
    end else begin
      state     <= state_next;
      cmp_valid <= (state == ST_SCAN);
      if (finish) begin
        out_v        <= 1'b1;
        access_clock <= stamp_t'(access_clock + 1'b1);
        if (state == ST_FILL && !evict)
          slots_in_use <= (SLOT_BITS+1)'(slots_in_use + 1'b1);
      end else if (rsp.ready) begin
        out_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx <= scan_idx;
    if (state == ST_IDLE && req.valid) begin
      cur_page <= page_t'(req.page_number);
      cur_cls  <= req.size_class;
      cur_wr   <= req.is_write;
      evict    <= 1'b0;
      scan_idx <= '0;
    end
    if (state == ST_LOOK) begin
      cnt_new   <= count_up(pt_rd_data.count);
      work_slot <= pt_rd_data.resident ? pt_rd_data.slot
                                       : slots_in_use[SLOT_BITS-1:0];
    end
    if (state == ST_SCAN) scan_idx <= slot_idx_t'(scan_idx + 1'b1);
    if (state == ST_EV_WR) begin
      work_slot <= best.idx;
      evict     <= 1'b1;
    end
    if (finish) begin
      rsp.hit                <= (state == ST_HIT_WR);
      rsp.slot               <= 8'(work_slot);
      rsp.fetch_needed       <= (state == ST_FILL) && !cur_wr;
      rsp.evicted_valid      <= (state == ST_FILL) && evict;
      rsp.evicted_page       <= ((state == ST_FILL) && evict) ? 16'(best.page) : 16'd0;
      rsp.evicted_writeback  <= (state == ST_FILL) && evict && best.dirty;
      rsp.evicted_size_class <= ((state == ST_FILL) && evict) ? best.cls : 2'd0;
    end
  end

  `LPC_ASSERT(a_fill_bound, slots_in_use <= (SLOT_BITS+1)'(CACHE_SLOTS), "slot fill overrun")
  `LPC_ASSERT(a_scan_full, state == ST_SCAN |-> slots_in_use == (SLOT_BITS+1)'(CACHE_SLOTS), "scan with free slot")
  `LPC_ASSERT(a_clock_step, finish |=> access_clock == stamp_t'($past(access_clock) + 1'b1), "access clock step")
  `LPC_ASSERT_RST(a_reset_clr, $past(rst) |-> state == ST_CLR, "no clear after reset")
endmodule

// ===== verif/lfu_tb_scoreboard.sv =====
// Scoreboard for the LFU page cache policy testbench: a predictor of the
// replacement policy and a queue of expected responses. Depends on lfu_pkg.
package lfu_tb_scoreboard_pkg;
  import lfu_pkg::*;

  typedef struct packed {
    logic        hit;
    logic [7:0]  slot;
    logic        fetch_needed;
    logic        evicted_valid;
    logic [15:0] evicted_page;
    logic        evicted_writeback;
    logic [1:0]  evicted_size_class;
  } policy_rsp_t;

  class lfu_policy_scoreboard;
    count_t      page_count [NUM_PAGES];
    bit          page_res [NUM_PAGES];
    slot_idx_t   page_slot [NUM_PAGES];
    page_t       slot_pg [CACHE_SLOTS];
    count_t      slot_cnt [CACHE_SLOTS];
    stamp_t      slot_stmp [CACHE_SLOTS];
    bit          slot_drt [CACHE_SLOTS];
    logic [1:0]  slot_cls [CACHE_SLOTS];
    int          used;
    stamp_t      clock_now;
    policy_rsp_t pending_rsp [$];
    int          errors;

    function new();
      foreach (page_count[i]) begin
        page_count[i] = '0;
        page_res[i] = 0;
      end
      used = 0;
      clock_now = '0;
      errors = 0;
    endfunction

    function count_t sat_inc(count_t c);
      return (c == {COUNT_BITS{1'b1}}) ? c : count_t'(c + 1);
    endfunction

    function int find_victim();
      int best;
      stamp_t age_i, age_b;
      best = 0;
      for (int i = 1; i < CACHE_SLOTS; i++) begin
        age_i = clock_now - slot_stmp[i];
        age_b = clock_now - slot_stmp[best];
        if (slot_cnt[i] < slot_cnt[best] ||
            (slot_cnt[i] == slot_cnt[best] && age_i > age_b))
          best = i;
      end
      return best;
    endfunction

    function void note_access(logic [15:0] pg, logic [1:0] cls, logic wr);
      policy_rsp_t r;
      int s;
      r = '0;
      page_count[pg] = sat_inc(page_count[pg]);
      if (page_res[pg]) begin
        r.hit = 1;
        s = page_slot[pg];
        slot_cnt[s] = sat_inc(slot_cnt[s]);
        if (wr) slot_drt[s] = 1;
      end else begin
        if (used < CACHE_SLOTS) begin
          s = used;
          used++;
        end else begin
          s = find_victim();
          r.evicted_valid = 1;
          r.evicted_page = slot_pg[s];
          r.evicted_writeback = slot_drt[s];
          r.evicted_size_class = slot_cls[s];
          page_res[slot_pg[s]] = 0;
        end
        slot_pg[s] = pg;
        slot_cls[s] = cls;
        slot_drt[s] = wr;
        slot_cnt[s] = page_count[pg];
        page_res[pg] = 1;
        page_slot[pg] = s;
        r.fetch_needed = !wr;
      end
      slot_stmp[s] = clock_now;
      clock_now = clock_now + 1;
      r.slot = s[7:0];
      pending_rsp.push_back(r);
    endfunction

    function void check_rsp(policy_rsp_t a);
      policy_rsp_t e;
      if (pending_rsp.size() == 0) begin
        $error("unexpected response %h", a);
        errors++;
        return;
      end
      e = pending_rsp.pop_front();
      if (a.hit !== e.hit) begin
        $error("hit exp %0d got %0d", e.hit, a.hit); errors++;
      end
      if (a.slot !== e.slot) begin
        $error("slot exp %0d got %0d", e.slot, a.slot); errors++;
      end
      if (a.fetch_needed !== e.fetch_needed) begin
        $error("fetch_needed exp %0d got %0d", e.fetch_needed, a.fetch_needed); errors++;
      end
      if (a.evicted_valid !== e.evicted_valid) begin
        $error("evicted_valid exp %0d got %0d", e.evicted_valid, a.evicted_valid); errors++;
      end
      if (a.evicted_page !== e.evicted_page) begin
        $error("evicted_page exp %0d got %0d", e.evicted_page, a.evicted_page); errors++;
      end
      if (a.evicted_writeback !== e.evicted_writeback) begin
        $error("evicted_writeback exp %0d got %0d", e.evicted_writeback,
               a.evicted_writeback);
        errors++;
      end
      if (a.evicted_size_class !== e.evicted_size_class) begin
        $error("evicted_size_class exp %0d got %0d", e.evicted_size_class,
               a.evicted_size_class);
        errors++;
      end
    endfunction
  endclass
endpackage

// ===== verif/tb.sv =====
// Top of the LFU page cache policy testbench: clock, reset, access driver,
// response sink with stalls. Depends on lfu_pkg, lfu_ifs, lfu_tb_scoreboard_pkg.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lfu_pkg::*;
  import lfu_tb_scoreboard_pkg::*;

  logic clk;
  logic rst;
  lfu_req_if req ();
  lfu_rsp_if rsp ();
  lfu_policy_scoreboard sb;
  bit quiet_phase;
  bit hold_rsp;
  logic [15:0] hot_pages [32];

  lfu_page_cache_policy DUT (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #400ms;
    $display("FAIL lfu_page_cache_policy");
    $finish;
  end

  task automatic send_access(logic [15:0] pg, logic [1:0] cls, logic wr);
    int gap;
    if (!quiet_phase && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 19);
      req.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1;
    req.page_number <= pg;
    req.size_class <= cls;
    req.is_write <= wr;
    do @(posedge clk); while (!req.ready);
    sb.note_access(pg, cls, wr);
  endtask

  task automatic drain_all();
    req.valid <= 0;
    while (sb.pending_rsp.size() != 0) @(posedge clk);
  endtask

  // response sink: random stalls, plus a long hold-off on request
  initial begin
    int stall;
    rsp.ready = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (rsp.valid && rsp.ready)
        sb.check_rsp({rsp.hit, rsp.slot, rsp.fetch_needed, rsp.evicted_valid,
                      rsp.evicted_page, rsp.evicted_writeback,
                      rsp.evicted_size_class});
      if (hold_rsp) begin
        rsp.ready <= 0;
        repeat (400) @(posedge clk);
        hold_rsp = 0;
        rsp.ready <= 1;
      end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 19);
        rsp.ready <= 0;
        repeat (stall) @(posedge clk);
        rsp.ready <= 1;
      end else begin
        rsp.ready <= 1;
      end
    end
  end

  initial begin
    int sent;
    int k;
    sb = new();
    quiet_phase = 0;
    hold_rsp = 0;
    rst = 1;
    req.valid = 0;
    req.page_number = '0;
    req.size_class = '0;
    req.is_write = 0;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: extremes, hit/miss, read/write
    send_access(16'h0000, 2'd0, 0);
    send_access(16'hFFFF, 2'd3, 1);
    send_access(16'h0000, 2'd1, 1);
    send_access(16'hFFFF, 2'd2, 0);
    send_access(16'h5555, 2'd2, 0);
    send_access(16'hAAAA, 2'd1, 1);
    drain_all();
    // fill the cache, then force evictions with equal counts (LRU tie-break)
    for (k = 6; k < CACHE_SLOTS + 12; k++)
      send_access(16'(16'h1000 + k), 2'(k), 1'(k & 1));
    drain_all();
    sent = 0;
    for (k = 0; k < 32; k++) hot_pages[k] = 16'($urandom);
    // long receiver hold-off while sender keeps offering
    hold_rsp = 1;
    while (sent < 480) begin
      if (sent == 240) drain_all();
      if (sent == 400) quiet_phase = 1;
      case ($urandom_range(0, 3))
        0: send_access(16'($urandom), 2'($urandom), 1'($urandom));
        1, 2: send_access(hot_pages[$urandom_range(0, 31)], 2'($urandom), 1'($urandom));
        default: send_access(16'(16'h2000 + $urandom_range(0, 300)), 2'($urandom),
                             1'($urandom));
      endcase
      sent++;
    end
    drain_all();
    repeat (CACHE_SLOTS + 20) @(posedge clk);
    if (sb.errors == 0 && sb.pending_rsp.size() == 0) begin
      $display("PASS lfu_page_cache_policy");
    end else begin
      $display("FAIL lfu_page_cache_policy");
    end
    $finish;
  end
endmodule
